@@ hw/rtl/pbcs_pkg.sv @@
// Shared types and constants of the priority burst-cap scheduler.
// Used by every RTL file of the block; depends on nothing.
package pbcs_pkg;

    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int QIDX_W  = 3;
    localparam int BURST_W = 8;
    localparam int QCNT_W  = 4;
    localparam int TOTAL_W = 32;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_PRIO_IDX  = 2'd0;
    localparam logic [1:0] REG_BURST_CAP = 2'd1;
    localparam logic [1:0] REG_QUEUE_CNT = 2'd2;

    localparam logic [QIDX_W-1:0]  PRIO_IDX_RST  = 3'd0;
    localparam logic [BURST_W-1:0] BURST_CAP_RST = 8'd8;
    localparam logic [QCNT_W-1:0]  QUEUE_CNT_RST = 4'd8;

    localparam logic [BURST_W-1:0] BURST_MAX = 8'hFF;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [QIDX_W-1:0] queue_index;
    } in_item_t;

    typedef struct packed {
        logic               granted;
        logic [QIDX_W-1:0]  granted_queue;
        logic               forced_classic;
        logic [BURST_W-1:0] burst_count_now;
        logic [TOTAL_W-1:0] forced_total;
    } out_item_t;

    typedef struct packed {
        logic [QIDX_W-1:0]  prio_idx;
        logic [BURST_W-1:0] burst_cap;
        logic [QCNT_W-1:0]  queue_count;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic enq_commit;
        logic wrap_step;
        logic deq_commit;
    } cmd_t;

    typedef struct packed {
        logic is_deq;
        logic cursor_high;
        logic out_busy;
    } stat_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

endpackage

@@ hw/rtl/pbcs_regs.sv @@
// APB-style configuration registers of the scheduler.
// Depends on pbcs_pkg.
module pbcs_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbcs_pkg::ADDR_W-1:0] paddr,
    input  logic [pbcs_pkg::DATA_W-1:0] pwdata,
    output logic [pbcs_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output pbcs_pkg::cfg_t              cfg
);

    pbcs_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prio_idx    <= pbcs_pkg::PRIO_IDX_RST;
            cfg_reg.burst_cap   <= pbcs_pkg::BURST_CAP_RST;
            cfg_reg.queue_count <= pbcs_pkg::QUEUE_CNT_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                pbcs_pkg::REG_PRIO_IDX:  cfg_reg.prio_idx    <= pwdata[pbcs_pkg::QIDX_W-1:0];
                pbcs_pkg::REG_BURST_CAP: cfg_reg.burst_cap   <= pwdata[pbcs_pkg::BURST_W-1:0];
                pbcs_pkg::REG_QUEUE_CNT: cfg_reg.queue_count <= pwdata[pbcs_pkg::QCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pbcs_pkg::REG_PRIO_IDX:  prdata = pbcs_pkg::DATA_W'(cfg_reg.prio_idx);
            pbcs_pkg::REG_BURST_CAP: prdata = pbcs_pkg::DATA_W'(cfg_reg.burst_cap);
            pbcs_pkg::REG_QUEUE_CNT: prdata = pbcs_pkg::DATA_W'(cfg_reg.queue_count);
            default:                 prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/pbcs_ctrl.sv @@
// Control state machine: takes an item, then sequences the cursor wrap
// and the enqueue or dequeue commit. Depends on pbcs_pkg.
module pbcs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pbcs_pkg::stat_t   stat,
    output pbcs_pkg::cmd_t    cmd
);

    pbcs_pkg::state_t state_reg;
    pbcs_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pbcs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            pbcs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = pbcs_pkg::ST_RUN;
                end
            end
            pbcs_pkg::ST_RUN: begin
                if (!stat.is_deq) begin
                    cmd.enq_commit = 1'b1;
                    state_next     = pbcs_pkg::ST_IDLE;
                end else if (stat.cursor_high) begin
                    // cursor left at or beyond a shrunk queue count: reduce it first
                    cmd.wrap_step = 1'b1;
                end else if (!stat.out_busy) begin
                    cmd.deq_commit = 1'b1;
                    state_next     = pbcs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pbcs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/pbcs_dp.sv @@
// Datapath: queue occupancy, burst counter, round-robin cursor, forced
// total, grant decision and output register. Depends on pbcs_pkg.
module pbcs_dp #(
    parameter int MAX_QUEUES  = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pbcs_pkg::cfg_t      cfg,
    input  pbcs_pkg::cmd_t      cmd,
    output pbcs_pkg::stat_t     stat,
    input  pbcs_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pbcs_pkg::out_item_t m_data
);

    localparam int CW = $clog2(MAX_QUEUES);
    localparam int NW = $clog2(MAX_QUEUES + 1);

    pbcs_pkg::in_item_t           in_reg;
    logic [COUNT_WIDTH-1:0]       occ_reg [MAX_QUEUES];
    logic [pbcs_pkg::BURST_W-1:0] burst_reg;
    logic [CW-1:0]                cursor_reg;
    logic [pbcs_pkg::TOTAL_W-1:0] forced_reg;
    logic                         m_valid_reg;
    pbcs_pkg::out_item_t          m_data_reg;

    logic [5:0]                   qc_ext;
    logic [5:0]                   n_wide;
    logic [NW-1:0]                n_use;
    logic [MAX_QUEUES-1:0]        nz;
    logic [MAX_QUEUES-1:0]        prio_hit;
    logic [MAX_QUEUES-1:0]        elig;
    logic [MAX_QUEUES-1:0]        upper;
    logic [MAX_QUEUES-1:0]        enq_hit;
    logic [MAX_QUEUES-1:0]        dec;
    logic                         up_found;
    logic                         all_found;
    logic [CW-1:0]                up_idx;
    logic [CW-1:0]                all_idx;
    logic [CW-1:0]                cls_idx;
    logic [NW-1:0]                cls_inc;
    logic [CW-1:0]                cursor_next;
    logic                         prio_ne;
    logic                         do_forced;
    logic                         do_prio;
    logic                         do_cls;
    logic [pbcs_pkg::BURST_W-1:0] burst_next;
    logic [pbcs_pkg::TOTAL_W-1:0] forced_next;
    logic [pbcs_pkg::QIDX_W-1:0]  grant_q;

    // queues in use: zero acts as one, clipped at MAX_QUEUES
    always_comb begin
        qc_ext = {2'b00, cfg.queue_count};
        if (qc_ext == 6'd0) begin
            n_wide = 6'd1;
        end else if (qc_ext > 6'(MAX_QUEUES)) begin
            n_wide = 6'(MAX_QUEUES);
        end else begin
            n_wide = qc_ext;
        end
        n_use = n_wide[NW-1:0];
    end

    always_comb begin
        for (int i = 0; i < MAX_QUEUES; i++) begin
            nz[i]       = (occ_reg[i] != '0);
            prio_hit[i] = (int'(cfg.prio_idx) == i);
            elig[i]     = nz[i] && (i < int'(n_use)) && !prio_hit[i];
            upper[i]    = elig[i] && (i >= int'(cursor_reg));
            enq_hit[i]  = (int'(in_reg.queue_index) == i);
        end
    end

    // round-robin pick: lowest eligible at or past the cursor, else lowest overall
    always_comb begin
        up_found  = 1'b0;
        all_found = 1'b0;
        up_idx    = '0;
        all_idx   = '0;
        for (int i = MAX_QUEUES - 1; i >= 0; i--) begin
            if (upper[i]) begin
                up_found = 1'b1;
                up_idx   = CW'(i);
            end
            if (elig[i]) begin
                all_found = 1'b1;
                all_idx   = CW'(i);
            end
        end
        cls_idx     = up_found ? up_idx : all_idx;
        cls_inc     = NW'(cls_idx) + NW'(1);
        cursor_next = (cls_inc == n_use) ? '0 : cls_inc[CW-1:0];
    end

    always_comb begin
        prio_ne   = |(nz & prio_hit);
        do_forced = (burst_reg >= cfg.burst_cap) && all_found;
        do_prio   = !do_forced && prio_ne;
        do_cls    = !do_forced && !do_prio && all_found;

        if (do_prio) begin
            burst_next = (burst_reg != pbcs_pkg::BURST_MAX) ? burst_reg + 8'd1 : burst_reg;
        end else begin
            burst_next = '0;
        end
        forced_next = forced_reg + pbcs_pkg::TOTAL_W'(do_forced);

        if (do_prio) begin
            grant_q = cfg.prio_idx;
        end else if (do_forced || do_cls) begin
            grant_q = pbcs_pkg::QIDX_W'(cls_idx);
        end else begin
            grant_q = '0;
        end

        for (int i = 0; i < MAX_QUEUES; i++) begin
            dec[i] = do_prio ? prio_hit[i] : ((do_forced || do_cls) && (int'(cls_idx) == i));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_QUEUES; i++) begin
                occ_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < MAX_QUEUES; i++) begin
                if (cmd.enq_commit && enq_hit[i] && (occ_reg[i] != '1)) begin
                    occ_reg[i] <= occ_reg[i] + COUNT_WIDTH'(1);
                end else if (cmd.deq_commit && dec[i]) begin
                    occ_reg[i] <= occ_reg[i] - COUNT_WIDTH'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_reg  <= '0;
            cursor_reg <= '0;
            forced_reg <= '0;
        end else if (cmd.wrap_step) begin
            cursor_reg <= cursor_reg - CW'(n_use);
        end else if (cmd.deq_commit) begin
            burst_reg  <= burst_next;
            forced_reg <= forced_next;
            if (do_forced || do_cls) begin
                cursor_reg <= cursor_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.deq_commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.deq_commit) begin
            m_data_reg.granted         <= do_forced || do_prio || do_cls;
            m_data_reg.granted_queue   <= grant_q;
            m_data_reg.forced_classic  <= do_forced;
            m_data_reg.burst_count_now <= burst_next;
            m_data_reg.forced_total    <= forced_next;
        end
    end

    assign stat.is_deq      = (in_reg.mode == pbcs_pkg::MODE_DEQ);
    assign stat.cursor_high = (NW'(cursor_reg) >= n_use);
    assign stat.out_busy    = m_valid_reg && !m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ hw/rtl/priority_burst_cap_rr_scheduler_top.sv @@
// Top level of the strict-priority scheduler with burst cap and classic round-robin.
// Instantiates pbcs_regs, pbcs_ctrl and pbcs_dp; depends on pbcs_pkg.
//
//   channel   ports                          handshake      carries
//   input     s_valid s_ready s_data         valid/ready    enqueue or dequeue event
//   result    m_valid m_ready m_data         valid/ready    grant decision (dequeue only)
//   config    psel penable pwrite paddr ...  apb, pready=1  three registers at 0x0/0x4/0x8
//
// each item is taken in ST_IDLE, then ST_RUN commits the count update or decision
// a dequeue first takes wrap steps while the cursor sits at or past queue_count
// a decision also waits while the output register holds a result not yet taken
// the output register lets a new item be taken while the last result waits
// aresetn is synchronous; reset clears all counts at once, no clearing pass
module priority_burst_cap_rr_scheduler_top #(
    parameter int MAX_QUEUES  = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  pbcs_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output pbcs_pkg::out_item_t         m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbcs_pkg::ADDR_W-1:0] paddr,
    input  logic [pbcs_pkg::DATA_W-1:0] pwdata,
    output logic [pbcs_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    pbcs_pkg::cfg_t  cfg;
    pbcs_pkg::cmd_t  cmd;
    pbcs_pkg::stat_t stat;

    pbcs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pbcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pbcs_dp #(
        .MAX_QUEUES  (MAX_QUEUES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .stat    (stat),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ hw/rtl/pbcs_checker.sv @@
// Port-level checks of the scheduler, bound to the top level.
// Depends on pbcs_pkg and priority_burst_cap_rr_scheduler_top.
module pbcs_sva (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input pbcs_pkg::out_item_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item taken in back-to-back cycles");

    // no grant carries no queue and no forced flag
    a_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.granted |-> !m_data.forced_classic && m_data.granted_queue == '0)
        else $error("empty decision carries grant fields");

    // a forced grant clears the burst counter
    a_forced_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.forced_classic |-> m_data.burst_count_now == '0)
        else $error("forced grant left burst counter set");

endmodule

bind priority_burst_cap_rr_scheduler_top pbcs_sva u_pbcs_sva (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ bench/pbcs_checker.sv @@
// Scoreboard for the priority burst-cap scheduler: follows register writes on the
// config port, predicts the decision of every dequeue event and compares results.
// Depends on pbcs_pkg.
module pbcs_checker #(
    parameter int MAX_QUEUES  = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  pbcs_pkg::in_item_t          s_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  pbcs_pkg::out_item_t         m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [pbcs_pkg::ADDR_W-1:0] paddr,
    input  logic [pbcs_pkg::DATA_W-1:0] pwdata,
    output int                          mismatch_count,
    output int                          pending_decisions
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [COUNT_WIDTH-1:0] OCC_FULL = '1;

    logic [pbcs_pkg::QIDX_W-1:0]  cfg_prio;
    logic [pbcs_pkg::BURST_W-1:0] cfg_cap;
    logic [pbcs_pkg::QCNT_W-1:0]  cfg_qcount;

    logic [COUNT_WIDTH-1:0]       occupancy [MAX_QUEUES];
    logic [pbcs_pkg::BURST_W-1:0] burst_run;
    int                           rr_cursor;
    logic [pbcs_pkg::TOTAL_W-1:0] forced_grants;
    pbcs_pkg::out_item_t          decision_q [$];

    // zero acts as one queue, anything past the array as all of them
    function automatic int queues_active();
        if (cfg_qcount == '0) begin
            return 1;
        end
        if (int'(cfg_qcount) > MAX_QUEUES) begin
            return MAX_QUEUES;
        end
        return int'(cfg_qcount);
    endfunction

    task automatic take_classic(output bit hit, output int winner);
        int n;
        int k;
        int cand;
        n = queues_active();
        hit = 1'b0;
        winner = 0;
        for (k = 0; k < n && !hit; k++) begin
            cand = (rr_cursor + k) % n;
            if (cand != int'(cfg_prio) && occupancy[cand] != '0) begin
                occupancy[cand] = occupancy[cand] - COUNT_WIDTH'(1);
                rr_cursor = (cand + 1) % n;
                winner = cand;
                hit = 1'b1;
            end
        end
    endtask

    task automatic predict_decision(input pbcs_pkg::in_item_t ev);
        pbcs_pkg::out_item_t dec;
        bit                  hit;
        int                  winner;
        if (ev.mode == pbcs_pkg::MODE_ENQ) begin
            if (int'(ev.queue_index) < MAX_QUEUES) begin
                if (occupancy[ev.queue_index] != OCC_FULL) begin
                    occupancy[ev.queue_index] = occupancy[ev.queue_index] + COUNT_WIDTH'(1);
                end
            end
            return;
        end
        dec = '0;
        hit = 1'b0;
        winner = 0;
        if (burst_run >= cfg_cap) begin
            take_classic(hit, winner);
            if (hit) begin
                dec.forced_classic = 1'b1;
                burst_run = '0;
                forced_grants = forced_grants + pbcs_pkg::TOTAL_W'(1);
            end
        end
        if (!hit && int'(cfg_prio) < MAX_QUEUES) begin
            if (occupancy[cfg_prio] != '0) begin
                occupancy[cfg_prio] = occupancy[cfg_prio] - COUNT_WIDTH'(1);
                if (burst_run != pbcs_pkg::BURST_MAX) begin
                    burst_run = burst_run + pbcs_pkg::BURST_W'(1);
                end
                winner = int'(cfg_prio);
                hit = 1'b1;
            end
        end
        // priority queue empty: counter clears, classic queues take turns
        if (!hit) begin
            burst_run = '0;
            take_classic(hit, winner);
        end
        dec.granted = hit;
        dec.granted_queue = hit ? winner[pbcs_pkg::QIDX_W-1:0] : '0;
        dec.burst_count_now = burst_run;
        dec.forced_total = forced_grants;
        decision_q.push_back(dec);
        pending_decisions = decision_q.size();
    endtask

    function automatic void compare_field(input string field, input logic [31:0] want_v,
                                          input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    task automatic check_decision(input pbcs_pkg::out_item_t got);
        pbcs_pkg::out_item_t want;
        if (decision_q.size() == 0) begin
            $error("decision item with no dequeue outstanding: %h", got);
            mismatch_count++;
            return;
        end
        want = decision_q.pop_front();
        pending_decisions = decision_q.size();
        compare_field("granted", 32'(want.granted), 32'(got.granted));
        compare_field("granted_queue", 32'(want.granted_queue), 32'(got.granted_queue));
        compare_field("forced_classic", 32'(want.forced_classic), 32'(got.forced_classic));
        compare_field("burst_count_now", 32'(want.burst_count_now), 32'(got.burst_count_now));
        compare_field("forced_total", want.forced_total, got.forced_total);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_prio = pbcs_pkg::PRIO_IDX_RST;
            cfg_cap = pbcs_pkg::BURST_CAP_RST;
            cfg_qcount = pbcs_pkg::QUEUE_CNT_RST;
            for (int q = 0; q < MAX_QUEUES; q++) begin
                occupancy[q] = '0;
            end
            burst_run = '0;
            rr_cursor = 0;
            forced_grants = '0;
            decision_q.delete();
            pending_decisions = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    pbcs_pkg::REG_PRIO_IDX: begin
                        cfg_prio = pwdata[pbcs_pkg::QIDX_W-1:0];
                    end
                    pbcs_pkg::REG_BURST_CAP: begin
                        cfg_cap = pwdata[pbcs_pkg::BURST_W-1:0];
                    end
                    pbcs_pkg::REG_QUEUE_CNT: begin
                        cfg_qcount = pwdata[pbcs_pkg::QCNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // older result first, so an item taken this edge cannot match it
            if (m_valid && m_ready) begin
                check_decision(m_data);
            end
            if (s_valid && s_ready) begin
                predict_decision(s_data);
            end
        end
    end

endmodule

@@ bench/priority_burst_cap_rr_scheduler_top_tb.sv @@
// Testbench top for the priority burst-cap scheduler: clock, reset, event and
// register stimulus, result-side stalls and the verdict.
// Depends on pbcs_pkg, priority_burst_cap_rr_scheduler_top and pbcs_checker.
module priority_burst_cap_rr_scheduler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_QUEUES  = 8;
    localparam int COUNT_WIDTH = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_GAP   = 12;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 82;
    localparam int FILL_ITEMS  = 40;
    localparam int DRAIN_ITEMS = 100;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    pbcs_pkg::in_item_t            s_data;
    logic                          m_valid;
    logic                          m_ready;
    pbcs_pkg::out_item_t           m_data;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [pbcs_pkg::ADDR_W-1:0]   paddr;
    logic [pbcs_pkg::DATA_W-1:0]   pwdata;
    logic [pbcs_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    int                            mismatch_count;
    int                            pending_decisions;
    bit                            hold_off_req;
    bit                            sink_always_ready;
    logic [pbcs_pkg::QIDX_W-1:0]   cur_prio;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    priority_burst_cap_rr_scheduler_top #(
        .MAX_QUEUES (MAX_QUEUES),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    pbcs_checker #(
        .MAX_QUEUES (MAX_QUEUES),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .mismatch_count   (mismatch_count),
        .pending_decisions(pending_decisions)
    );

    function automatic pbcs_pkg::in_item_t ev(input logic mode, input int q);
        pbcs_pkg::in_item_t it;
        it.mode = mode;
        it.queue_index = q[pbcs_pkg::QIDX_W-1:0];
        return it;
    endfunction

    // lean toward the priority queue so bursts build up against waiting classics
    function automatic pbcs_pkg::in_item_t pick_event();
        pbcs_pkg::in_item_t it;
        it.mode = ($urandom_range(0, 99) < 48) ? pbcs_pkg::MODE_ENQ : pbcs_pkg::MODE_DEQ;
        if ($urandom_range(0, 2) == 0) begin
            it.queue_index = cur_prio;
        end else begin
            it.queue_index = pbcs_pkg::QIDX_W'($urandom_range(0, 7));
        end
        return it;
    endfunction

    task automatic offer(input pbcs_pkg::in_item_t it);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic rest(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // enqueues give no result, so allow the block time to finish the last one
    task automatic settle();
        rest(1);
        wait (pending_decisions == 0);
        rest(DRAIN_GAP);
    endtask

    task automatic apb_write(input logic [1:0] idx, input int unsigned value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input int prio, input int cap, input int qcount);
        apb_write(pbcs_pkg::REG_PRIO_IDX, prio);
        apb_write(pbcs_pkg::REG_BURST_CAP, cap);
        apb_write(pbcs_pkg::REG_QUEUE_CNT, qcount);
        cur_prio = prio[pbcs_pkg::QIDX_W-1:0];
    endtask

    task automatic run_traffic(input int items, input bit bursty);
        int left;
        int burst;
        left = items;
        while (left > 0) begin
            burst = bursty ? $urandom_range(1, 20) : left;
            while (burst > 0 && left > 0) begin
                offer(pick_event());
                burst--;
                left--;
            end
            if (bursty && left > 0) begin
                rest($urandom_range(1, 8));
            end
        end
    endtask

    initial begin : result_sink
        int  run_left;
        bit  want_ready;
        m_ready = 1'b0;
        run_left = 0;
        want_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_off_req = 1'b0;
                run_left = 0;
            end else if (sink_always_ready) begin
                m_ready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    want_ready = !want_ready;
                    run_left = want_ready ? $urandom_range(1, 16) : $urandom_range(1, 5);
                end
                m_ready <= want_ready;
                run_left--;
            end
        end
    end

    initial begin : stimulus
        int  ph;
        bit  calm;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        hold_off_req = 1'b0;
        sink_always_ready = 1'b1;
        cur_prio = pbcs_pkg::PRIO_IDX_RST;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: empty grant, priority first, then classic round-robin
        offer(ev(pbcs_pkg::MODE_DEQ, 5));
        offer(ev(pbcs_pkg::MODE_ENQ, 0));
        offer(ev(pbcs_pkg::MODE_ENQ, 7));
        offer(ev(pbcs_pkg::MODE_ENQ, 3));
        offer(ev(pbcs_pkg::MODE_ENQ, 0));
        repeat (5) offer(ev(pbcs_pkg::MODE_DEQ, 7));
        settle();

        // cap of one forces classics; queue 5 lies past queue_count and is never reached
        set_config(2, 1, 3);
        repeat (3) offer(ev(pbcs_pkg::MODE_ENQ, 2));
        offer(ev(pbcs_pkg::MODE_ENQ, 0));
        offer(ev(pbcs_pkg::MODE_ENQ, 1));
        offer(ev(pbcs_pkg::MODE_ENQ, 5));
        repeat (6) offer(ev(pbcs_pkg::MODE_DEQ, 0));
        settle();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_config(7, 1, 8);
                1: set_config(0, 255, 8);
                2: set_config(3, 0, 5);
                3: set_config(5, 2, 3);
                4: set_config(1, 4, 0);
                5: set_config(6, 3, 15);
                6: set_config(2, 1, 1);
                default: set_config($urandom_range(0, 7), $urandom_range(0, 6),
                                    $urandom_range(0, 15));
            endcase
            calm = (ph == 1 || ph == 6);
            sink_always_ready = calm;
            if (ph == 3) begin
                // result side blocks for a long stretch while events keep coming
                hold_off_req = 1'b1;
            end
            if (ph == 5) begin
                run_traffic(PHASE_ITEMS / 2, 1'b1);
                rest(1);
                wait (pending_decisions == 0);
                rest($urandom_range(5, 20));
                run_traffic(PHASE_ITEMS - PHASE_ITEMS / 2, 1'b1);
            end else begin
                run_traffic(PHASE_ITEMS, !calm);
            end
            settle();
        end

        // load the priority queue, then a long run of dequeues
        sink_always_ready = 1'b1;
        set_config(7, 255, 8);
        repeat (FILL_ITEMS) offer(ev(pbcs_pkg::MODE_ENQ, 7));
        repeat (DRAIN_ITEMS) offer(ev(pbcs_pkg::MODE_DEQ, $urandom_range(0, 7)));
        settle();
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #12_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
